[hdl/dq_pkg.sv]
package dq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned NAME_W    = 64;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STAT_W    = 2;
  // wide enough for position plus count against DEPTH up to 64
  localparam int unsigned CMP_W     = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_LIST_FWD   = 3'd5,
    CMD_LIST_BWD   = 3'd6
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOLIST = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [NAME_W-1:0] name;
  } rec_t;

  typedef struct packed {
    logic shl;
    logic shr;
  } cell_ctl_t;

endpackage

[hdl/dq_cmd_if.sv]
interface dq_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [dq_pkg::CMD_W-1:0]   command;
  logic [dq_pkg::ID_W-1:0]    student_id;
  logic [dq_pkg::NAME_W-1:0]  name_word;
  logic [dq_pkg::POS_W-1:0]   position;

  modport source (output valid, command, student_id, name_word, position, input ready);
  modport sink   (input valid, command, student_id, name_word, position, output ready);
endinterface

[hdl/dq_rsp_if.sv]
interface dq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [dq_pkg::STAT_W-1:0]  status;
  logic [dq_pkg::ID_W-1:0]    out_id;
  logic [dq_pkg::NAME_W-1:0]  out_name;
  logic                       last;

  modport source (output valid, status, out_id, out_name, last, input ready);
  modport sink   (input valid, status, out_id, out_name, last, output ready);
endinterface

[hdl/double_ended_queue_core.sv]
// Bounded double-ended queue of id/name records held in a row of DEPTH cells,
// front entry in cell 0. Commands arrive on cmd_i (valid/ready), results
// leave on rsp_o (valid/ready) through one output register.
// Push, pop, clear and an unknown command, once taken, give one registered word
// in the next cycle, with last set; the next command may be taken in the
// same cycle the result is taken.
// A listing whose position is below the count rotates the whole cell row once
// around, one step per cycle unless a stalled receiver holds it, and emits a
// word each step the watched end cell holds an entry of the listing window:
// forward watches cell 0 rotating left, backward watches the far cell rotating
// right. The listing marks its final word last.
// A listing with a position not below the count gives one word with status 3.
// cmd_i.ready is low while a listing runs and while a result waits that the
// receiver has not taken; a stalled receiver holds the rotation in place.
// Reset clears the count, the state and the output valid; record storage
// holds no defined value until written.
module double_ended_queue_core #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_cmd_if.sink   cmd_i,
  dq_rsp_if.source rsp_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = dq_pkg::CMP_W;

  dq_pkg::state_e state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [IW-1:0]  r_q, r_d;
  logic           dir_q, dir_d;
  logic [dq_pkg::POS_W-1:0] pos_q, pos_d;

  logic                       rsp_valid_q, rsp_valid_d;
  logic [dq_pkg::STAT_W-1:0]  rsp_status_q, rsp_status_d;
  dq_pkg::rec_t               rsp_rec_q, rsp_rec_d;
  logic                       rsp_last_q, rsp_last_d;
  logic                       rsp_load;

  dq_pkg::rec_t      cell_rec [DEPTH];
  dq_pkg::rec_t      new_rec;
  dq_pkg::rec_t      head_in;
  dq_pkg::rec_t      tap;
  dq_pkg::cell_ctl_t ctl;
  logic [DEPTH-1:0]  load_vec;

  logic slot_free, fire, full, empty, emit, lst_last, advance, push_back_go;
  logic [SW-1:0] r_x, cnt_x, pos_x, in_pos_x, dep_x;

  assign new_rec.id   = cmd_i.student_id;
  assign new_rec.name = cmd_i.name_word;
  assign head_in      = (state_q == dq_pkg::S_LIST) ? cell_rec[DEPTH-1] : new_rec;
  assign tap          = dir_q ? cell_rec[DEPTH-1] : cell_rec[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dq_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .load_i (load_vec[i]),
      .prev_i ((i == 0) ? head_in : cell_rec[(i + DEPTH - 1) % DEPTH]),
      .next_i (cell_rec[(i + 1) % DEPTH]),
      .new_i  (new_rec),
      .rec_o  (cell_rec[i])
    );
    assign load_vec[i] = push_back_go && (cnt_q == CW'(i));
  end

  assign slot_free = !rsp_valid_q || rsp_o.ready;
  assign cmd_i.ready = (state_q == dq_pkg::S_IDLE) && slot_free;
  assign fire  = cmd_i.valid && cmd_i.ready;
  assign full  = (cnt_q == CW'(DEPTH));
  assign empty = (cnt_q == '0);
  assign push_back_go = fire && !full
                        && (dq_pkg::cmd_e'(cmd_i.command) == dq_pkg::CMD_PUSH_BACK);

  assign r_x      = SW'(r_q);
  assign cnt_x    = SW'(cnt_q);
  assign pos_x    = SW'(pos_q);
  assign in_pos_x = SW'(cmd_i.position);
  assign dep_x    = SW'(DEPTH);

  always_comb begin
    if (dir_q) begin
      emit     = (r_x + cnt_x) >= (dep_x + pos_x);
      lst_last = (r_q == IW'(DEPTH - 1));
    end else begin
      emit     = (r_x >= pos_x) && (r_x < cnt_x);
      lst_last = ((r_x + SW'(1)) == cnt_x);
    end
  end

  assign advance = !emit || slot_free;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    r_d          = r_q;
    dir_d        = dir_q;
    pos_d        = pos_q;
    ctl          = '0;
    rsp_load     = 1'b0;
    rsp_status_d = dq_pkg::ST_OK;
    rsp_rec_d    = '0;
    rsp_last_d   = 1'b1;

    unique case (state_q)
      dq_pkg::S_IDLE: begin
        if (fire) begin
          rsp_load = 1'b1;
          unique case (dq_pkg::cmd_e'(cmd_i.command))
            dq_pkg::CMD_PUSH_FRONT: begin
              if (full) begin
                rsp_status_d = dq_pkg::ST_FULL;
              end else begin
                ctl.shr = 1'b1;
                cnt_d   = cnt_q + CW'(1);
              end
            end
            dq_pkg::CMD_PUSH_BACK: begin
              if (full) begin
                rsp_status_d = dq_pkg::ST_FULL;
              end else begin
                cnt_d = cnt_q + CW'(1);
              end
            end
            dq_pkg::CMD_POP_FRONT: begin
              if (empty) begin
                rsp_status_d = dq_pkg::ST_EMPTY;
              end else begin
                ctl.shl = 1'b1;
                cnt_d   = cnt_q - CW'(1);
              end
            end
            dq_pkg::CMD_POP_BACK: begin
              if (empty) begin
                rsp_status_d = dq_pkg::ST_EMPTY;
              end else begin
                cnt_d = cnt_q - CW'(1);
              end
            end
            dq_pkg::CMD_CLEAR: begin
              cnt_d = '0;
            end
            dq_pkg::CMD_LIST_FWD, dq_pkg::CMD_LIST_BWD: begin
              if (in_pos_x >= cnt_x) begin
                rsp_status_d = dq_pkg::ST_NOLIST;
              end else begin
                rsp_load = 1'b0;
                state_d  = dq_pkg::S_LIST;
                r_d      = '0;
                pos_d    = cmd_i.position;
                dir_d    = (dq_pkg::cmd_e'(cmd_i.command) == dq_pkg::CMD_LIST_BWD);
              end
            end
            default: begin
            end
          endcase
        end
      end
      dq_pkg::S_LIST: begin
        if (advance) begin
          ctl.shl = !dir_q;
          ctl.shr = dir_q;
          r_d     = r_q + IW'(1);
          if (emit) begin
            rsp_load   = 1'b1;
            rsp_rec_d  = tap;
            rsp_last_d = lst_last;
          end
          if (r_q == IW'(DEPTH - 1)) begin
            state_d = dq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = dq_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp_valid_d = rsp_load ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::S_IDLE;
      cnt_q       <= '0;
      r_q         <= '0;
      dir_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      r_q         <= r_d;
      dir_q       <= dir_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (rsp_load) begin
      rsp_status_q <= rsp_status_d;
      rsp_rec_q    <= rsp_rec_d;
      rsp_last_q   <= rsp_last_d;
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.status   = rsp_status_q;
  assign rsp_o.out_id   = rsp_rec_q.id;
  assign rsp_o.out_name = rsp_rec_q.name;
  assign rsp_o.last     = rsp_last_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_no_cmd_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dq_pkg::S_LIST) |-> !cmd_i.ready)
    else $error("command taken during listing");

  a_shift_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.shl && ctl.shr) && $onehot0(load_vec))
    else $error("conflicting cell controls");

  a_list_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dq_pkg::S_LIST && advance && r_q == IW'(DEPTH - 1))
      |=> (state_q == dq_pkg::S_IDLE && cnt_q == $past(cnt_q)))
    else $error("listing did not end after full rotation");

  a_list_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dq_pkg::S_LIST) |=> $stable(cnt_q))
    else $error("count changed during listing");
`endif

endmodule

[hdl/dq_cell.sv]
module dq_cell (
  input  logic              clk_i,
  input  dq_pkg::cell_ctl_t ctl_i,
  input  logic              load_i,
  input  dq_pkg::rec_t      prev_i,
  input  dq_pkg::rec_t      next_i,
  input  dq_pkg::rec_t      new_i,
  output dq_pkg::rec_t      rec_o
);

  dq_pkg::rec_t rec_q;
  dq_pkg::rec_t rec_d;

  always_comb begin
    priority if (load_i) begin
      rec_d = new_i;
    end else if (ctl_i.shl) begin
      rec_d = next_i;
    end else if (ctl_i.shr) begin
      rec_d = prev_i;
    end else begin
      rec_d = rec_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule
